// ===== hdl/triangle_area_heron_top_defines.svh =====
// Assertion macros used by the checker file of the triangle area block.
`ifndef TRIANGLE_AREA_HERON_TOP_DEFINES_SVH
`define TRIANGLE_AREA_HERON_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TAH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define TAH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Same-cycle implication, also checked while in reset.
`define TAH_ASSERT_ALWAYS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hdl/tah_pkg.sv =====
// Widths and latencies of the triangle area pipeline.
package tah_pkg;
	localparam int COORD_W   = 16;
	localparam int FRAC_BITS = 8;
	localparam int DELTA_W   = COORD_W + 1;
	localparam int SQ_W      = 2 * DELTA_W;
	localparam int D2_W      = SQ_W + 2;
	localparam int ERAD_W    = D2_W + 2 * FRAC_BITS + 2;
	localparam int EROOT_W   = ERAD_W / 2;
	localparam int EDGE_W    = EROOT_W;
	localparam int S_W       = EDGE_W + 2;
	localparam int P_W       = 2 * S_W;
	localparam int PROD_W    = 2 * P_W;
	localparam int ROOT_W    = P_W;
	localparam int AREA_W    = 41;
	localparam int EDGE_LAT  = 3 + EROOT_W + 1;
	localparam int HERON_LAT = 6;
	localparam int TOTAL_LAT = EDGE_LAT + HERON_LAT + ROOT_W + 1;
endpackage

// ===== hdl/tah_edge.sv =====
// Edge length pipeline: squared distance, then one root bit per stage, then rounding.
module tah_edge import tah_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [COORD_W-1:0] p_x,
	input  logic signed [COORD_W-1:0] p_y,
	input  logic signed [COORD_W-1:0] p_z,
	input  logic signed [COORD_W-1:0] q_x,
	input  logic signed [COORD_W-1:0] q_y,
	input  logic signed [COORD_W-1:0] q_z,
	output logic        [EDGE_W-1:0]  len
);
	localparam int REM_W = EROOT_W + 2;

	logic signed [DELTA_W-1:0] dx_s1, dy_s1, dz_s1;
	logic        [SQ_W-1:0]    sx_s2, sy_s2, sz_s2;
	logic        [D2_W-1:0]    d2_s3;
	logic        [ERAD_W-1:0]  rad_s  [0:EROOT_W];
	logic        [REM_W-1:0]   rem_s  [0:EROOT_W];
	logic        [EROOT_W-1:0] root_s [0:EROOT_W];
	logic        [EDGE_W-1:0]  len_s;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DELTA_W'(q_x) - DELTA_W'(p_x);
			dy_s1 <= DELTA_W'(q_y) - DELTA_W'(p_y);
			dz_s1 <= DELTA_W'(q_z) - DELTA_W'(p_z);
			sx_s2 <= SQ_W'(dx_s1) * SQ_W'(dx_s1);
			sy_s2 <= SQ_W'(dy_s1) * SQ_W'(dy_s1);
			sz_s2 <= SQ_W'(dz_s1) * SQ_W'(dz_s1);
			d2_s3 <= D2_W'(sx_s2) + D2_W'(sy_s2) + D2_W'(sz_s2);
		end
	end

	assign rad_s[0]  = {d2_s3, (ERAD_W - D2_W)'(0)};
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	genvar k;
	for (k = 0; k < EROOT_W; k++) begin : g_root
		logic [REM_W+1:0] rem_sh, trial, diff;
		logic             ge;
		always_comb begin
			rem_sh = {rem_s[k], rad_s[k][ERAD_W-1 -: 2]};
			trial  = (REM_W + 2)'({root_s[k], 2'b01});
			diff   = rem_sh - trial;
			ge     = (rem_sh >= trial);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= {rad_s[k][ERAD_W-3:0], 2'b00};
				rem_s[k+1]  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
				root_s[k+1] <= {root_s[k][EROOT_W-2:0], ge};
			end
		end
	end

	logic [EROOT_W:0] rnd;
	assign rnd = (EROOT_W + 1)'(root_s[EROOT_W]) + (EROOT_W + 1)'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			len_s <= rnd[EDGE_W:1];
		end
	end

	assign len = len_s;
endmodule

// ===== hdl/triangle_area_heron_top.sv =====
// Top level: 3D triangle area by Heron's formula, fully pipelined.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid, in_stall, a_* b_* c_* (x,y,z) | into block
//  out     | out_valid, out_stall, area            | out of block
//
// One transaction enters per cycle unless a waiting result is stalled; the stages are a
// 31-stage edge length pipeline, six Heron stages, one stage per bit of the 58-bit
// area root and one rounding stage. The root pipelines set the depth, not the rate.
// Reset clears only the valid bits; data registers are not reset.
// A stalled output freezes the whole pipeline, bubbles included, so in_stall
// follows out_stall whenever a result is waiting.
module triangle_area_heron_top import tah_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [COORD_W-1:0] a_x,
	input  logic signed [COORD_W-1:0] a_y,
	input  logic signed [COORD_W-1:0] a_z,
	input  logic signed [COORD_W-1:0] b_x,
	input  logic signed [COORD_W-1:0] b_y,
	input  logic signed [COORD_W-1:0] b_z,
	input  logic signed [COORD_W-1:0] c_x,
	input  logic signed [COORD_W-1:0] c_y,
	input  logic signed [COORD_W-1:0] c_z,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic        [AREA_W-1:0]  area
);
	localparam int REM_W = ROOT_W + 2;
	localparam int HALF  = S_W;

	// Global advance: move unless a finished result is held by the sink.
	logic en;
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// Valid bits travel alongside the data.
	logic vld_s [0:TOTAL_LAT-1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOTAL_LAT; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < TOTAL_LAT; i++) vld_s[i] <= vld_s[i-1];
		end
	end
	assign out_valid = vld_s[TOTAL_LAT-1];

	// Edge lengths: |b-a|, |c-b|, |a-c|.
	logic [EDGE_W-1:0] ea, eb, ec;
	tah_edge u_edge_a (.clk(clk), .en(en), .p_x(a_x), .p_y(a_y), .p_z(a_z),
		.q_x(b_x), .q_y(b_y), .q_z(b_z), .len(ea));
	tah_edge u_edge_b (.clk(clk), .en(en), .p_x(b_x), .p_y(b_y), .p_z(b_z),
		.q_x(c_x), .q_y(c_y), .q_z(c_z), .len(eb));
	tah_edge u_edge_c (.clk(clk), .en(en), .p_x(c_x), .p_y(c_y), .p_z(c_z),
		.q_x(a_x), .q_y(a_y), .q_z(a_z), .len(ec));

	// Heron factors in doubled form: S and S-2a, S-2b, S-2c.
	logic [EDGE_W-1:0] ea_s1, eb_s1, ec_s1;
	logic [S_W-1:0]    s_s1;
	logic [S_W-1:0]    s_s2, fa_s2, fb_s2, fc_s2;
	logic              ok_s2, ok_s3, ok_s4, ok_s5;
	logic [P_W-1:0]    p1_s3, p2_s3;
	logic [P_W-1:0]    ll_s4, lh_s4, hl_s4, hh_s4;
	logic [P_W-1:0]    ll_s5, hh_s5;
	logic [P_W:0]      mid_s5;
	logic [PROD_W-1:0] prod_s6;

	logic signed [S_W:0] fa_w, fb_w, fc_w, s_w;
	always_comb begin
		s_w  = $signed({1'b0, s_s1});
		fa_w = s_w - $signed((S_W + 1)'({ea_s1, 1'b0}));
		fb_w = s_w - $signed((S_W + 1)'({eb_s1, 1'b0}));
		fc_w = s_w - $signed((S_W + 1)'({ec_s1, 1'b0}));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ea_s1  <= ea;
			eb_s1  <= eb;
			ec_s1  <= ec;
			s_s1   <= S_W'(ea) + S_W'(eb) + S_W'(ec);
			// degenerate or rounding-negative triangle gives zero area
			ok_s2  <= (s_w > 0) && (fa_w > 0) && (fb_w > 0) && (fc_w > 0);
			s_s2   <= s_s1;
			fa_s2  <= fa_w[S_W-1:0];
			fb_s2  <= fb_w[S_W-1:0];
			fc_s2  <= fc_w[S_W-1:0];
			ok_s3  <= ok_s2;
			p1_s3  <= P_W'(s_s2) * P_W'(fa_s2);
			p2_s3  <= P_W'(fb_s2) * P_W'(fc_s2);
			// 16*A^2 split into four narrow partial products
			ok_s4  <= ok_s3;
			ll_s4  <= P_W'(p1_s3[HALF-1:0]) * P_W'(p2_s3[HALF-1:0]);
			lh_s4  <= P_W'(p1_s3[HALF-1:0]) * P_W'(p2_s3[P_W-1:HALF]);
			hl_s4  <= P_W'(p1_s3[P_W-1:HALF]) * P_W'(p2_s3[HALF-1:0]);
			hh_s4  <= P_W'(p1_s3[P_W-1:HALF]) * P_W'(p2_s3[P_W-1:HALF]);
			ok_s5  <= ok_s4;
			ll_s5  <= ll_s4;
			hh_s5  <= hh_s4;
			mid_s5 <= (P_W + 1)'(lh_s4) + (P_W + 1)'(hl_s4);
			prod_s6 <= ok_s5 ? ({hh_s5, P_W'(0)} + (PROD_W'(mid_s5) << HALF)
				+ PROD_W'(ll_s5)) : '0;
		end
	end

	// Area root: one result bit per stage.
	logic [PROD_W-1:0] rad_s  [0:ROOT_W];
	logic [REM_W-1:0]  rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];

	assign rad_s[0]  = prod_s6;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	genvar k;
	for (k = 0; k < ROOT_W; k++) begin : g_root
		logic [REM_W+1:0] rem_sh, trial, diff;
		logic             ge;
		always_comb begin
			rem_sh = {rem_s[k], rad_s[k][PROD_W-1 -: 2]};
			trial  = (REM_W + 2)'({root_s[k], 2'b01});
			diff   = rem_sh - trial;
			ge     = (rem_sh >= trial);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= {rad_s[k][PROD_W-3:0], 2'b00};
				rem_s[k+1]  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
				root_s[k+1] <= {root_s[k][ROOT_W-2:0], ge};
			end
		end
	end

	// Undo the factor 4 * 2^FRAC_BITS, rounding half up.
	logic [ROOT_W:0]   rnd;
	logic [AREA_W-1:0] area_s;
	assign rnd = (ROOT_W + 1)'(root_s[ROOT_W]) + ((ROOT_W + 1)'(1) << (FRAC_BITS + 1));

	always_ff @(posedge clk) begin
		if (en) begin
			area_s <= rnd[FRAC_BITS+2 +: AREA_W];
		end
	end

	assign area = area_s;
endmodule

// ===== hdl/tah_check.sv =====
// Port-level checker for the triangle area block, bound to the top level.
`include "triangle_area_heron_top_defines.svh"

module tah_check import tah_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [AREA_W-1:0] area
);
	`TAH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "out valid dropped under stall")
	`TAH_ASSERT_NEXT(a_area_hold, out_valid && out_stall, $stable(area), "area changed under stall")
	`TAH_ASSERT_NOW(a_back_stall, 1'b1, in_stall == (out_valid && out_stall), "input stall mismatch")
	`TAH_ASSERT_ALWAYS(a_empty_reset, !$past(arst_n), !out_valid, "result right after reset")
endmodule

bind triangle_area_heron_top tah_check u_tah_check (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .area(area)
);

// ===== tb/triangle_area_heron_top_test.sv =====
// Testbench for the 3D triangle area block: directed table plus random corners, scoreboard.
module triangle_area_heron_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import tah_pkg::*;

	localparam int N_RANDOM  = 450;
	localparam int PAUSE_AT  = 230;    // sender drains the pipeline once here
	localparam int TAIL_CYC  = 2 * TOTAL_LAT + 20;
	localparam int CYC_LIMIT = 200000;

	// One triangle; known=1 means the area below is typed in, else it is predicted.
	typedef struct {
		logic signed [COORD_W-1:0] crd [9];
		bit                        known;
		logic        [AREA_W-1:0]  area;
	} triangle_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic signed [COORD_W-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
	logic                      out_valid;
	logic                      out_stall;
	logic        [AREA_W-1:0]  area;

	triangle_t          triangles[$];
	logic [AREA_W-1:0]  pending_areas[$];   // expected areas, oldest first
	bit                 known_q[$];          // known flags of rows driven but not yet accepted
	logic [AREA_W-1:0]  known_area_q[$];
	int                 errors;
	int                 cycles;
	int                 sent;
	int                 snd_idle;            // sender idle chance, percent
	int                 rcv_idle;            // receiver stall chance, percent
	bit                 draining;

	triangle_area_heron_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.a_x(a_x), .a_y(a_y), .a_z(a_z),
		.b_x(b_x), .b_y(b_y), .b_z(b_z),
		.c_x(c_x), .c_y(c_y), .c_z(c_z),
		.out_valid(out_valid), .out_stall(out_stall), .area(area)
	);

	// Floor square root of a 128-bit value, one result bit per step.
	function automatic logic [63:0] floor_root(input logic [127:0] v);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= v)
				r = c;
		end
		return r;
	endfunction

	// Edge length rounded to nearest with FRAC_BITS fraction bits.
	function automatic longint edge_length(input longint dx, input longint dy, input longint dz);
		logic [127:0] rad;
		longint d2;
		d2  = dx * dx + dy * dy + dz * dz;
		rad = {64'd0, d2} << (2 * FRAC_BITS + 2);
		return longint'((floor_root(rad) + 64'd1) >> 1);
	endfunction

	function automatic logic [AREA_W-1:0] heron_area(input triangle_t t);
		longint p [9];
		longint ea, eb, ec, s, fa, fb, fc;
		logic [127:0] prod;
		logic [63:0]  r;
		for (int i = 0; i < 9; i++)
			p[i] = longint'(t.crd[i]);
		ea = edge_length(p[3] - p[0], p[4] - p[1], p[5] - p[2]);
		eb = edge_length(p[6] - p[3], p[7] - p[4], p[8] - p[5]);
		ec = edge_length(p[0] - p[6], p[1] - p[7], p[2] - p[8]);
		s  = ea + eb + ec;
		fa = s - 2 * ea;
		fb = s - 2 * eb;
		fc = s - 2 * ec;
		// degenerate or rounding-negative factors clamp to zero
		if (s <= 0 || fa <= 0 || fb <= 0 || fc <= 0)
			return '0;
		prod = ({64'd0, s * fa}) * ({64'd0, fb * fc});
		r = floor_root(prod);
		return AREA_W'((r + (64'd1 << (FRAC_BITS + 1))) >> (FRAC_BITS + 2));
	endfunction

	function automatic triangle_t make_tri(input int v [9], input bit known,
		input logic [AREA_W-1:0] a);
		triangle_t t;
		for (int i = 0; i < 9; i++)
			t.crd[i] = COORD_W'(v[i]);
		t.known = known;
		t.area  = a;
		return t;
	endfunction

	// Directed table, then random corners.
	task automatic build_stimulus();
		int v [9];
		int mode;
		// all corners equal: zero area
		triangles.push_back(make_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '0));
		// collinear corners: one Heron factor is exactly zero
		triangles.push_back(make_tri('{0, 0, 0, 1, 0, 0, 2, 0, 0}, 1, '0));
		// 3-4-5 right triangle: area 6.0
		triangles.push_back(make_tri('{0, 0, 0, 3, 0, 0, 0, 4, 0}, 1, 41'd1536));
		triangles.push_back(make_tri('{0, 0, 0, 0, 3, 0, 0, 0, 4}, 0, '0));
		triangles.push_back(make_tri('{1, 1, 1, 2, 3, 5, -4, 7, 2}, 0, '0));
		// extremes of the coordinate range
		triangles.push_back(make_tri('{-32768, -32768, -32768, 32767, 32767, 32767,
			-32768, 32767, -32768}, 0, '0));
		triangles.push_back(make_tri('{32767, -32768, 32767, -32768, 32767, -32768,
			32767, 32767, -32768}, 0, '0));
		triangles.push_back(make_tri('{-32768, -32768, 0, 32767, -32768, 0,
			-32768, 32767, 0}, 0, '0));
		triangles.push_back(make_tri('{-32768, 0, 0, 32767, 0, 0, 0, 32767, 32767}, 0, '0));
		triangles.push_back(make_tri('{-32768, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768, -32768}, 1, '0));
		triangles.push_back(make_tri('{32767, 32767, 32767, 32767, 32767, 32767,
			-32768, -32768, -32768}, 1, '0));
		// nearly degenerate: edge rounding may push a factor negative
		triangles.push_back(make_tri('{0, 0, 0, 1, 1, 1, 3, 3, 2}, 0, '0));
		triangles.push_back(make_tri('{0, 0, 0, 1000, 1, 0, 2000, 1, 0}, 0, '0));
		triangles.push_back(make_tri('{-1, -1, -1, 0, 0, 0, 1, 1, 1}, 1, '0));
		for (int n = 0; n < N_RANDOM; n++) begin
			mode = $urandom_range(0, 9);
			for (int i = 0; i < 9; i++) begin
				if (mode < 5)
					v[i] = $signed(16'($urandom));
				else if (mode < 8)
					v[i] = $urandom_range(0, 16) - 8;
				else
					v[i] = (i % 3 == 0) ? $urandom_range(0, 40) - 20 : 0;  // collinear: all corners on the x axis
			end
			if (mode == 9) begin
				// corner c on the line through a and b
				for (int i = 0; i < 3; i++)
					v[6 + i] = 2 * v[3 + i] - v[i];
			end
			triangles.push_back(make_tri(v, 0, '0));
		end
	endtask

	// Clock and cycle limit
	initial begin
		clk    = 1'b0;
		cycles = 0;
		forever begin
			#1 clk = ~clk;
			if (clk) begin
				cycles++;
				if (cycles > CYC_LIMIT) begin
					$display("Verification failed");
					$finish;
				end
			end
		end
	end

	// Receiver: random stalls following the current idle mix
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			out_stall <= ($urandom_range(0, 99) < rcv_idle);
		end
	end

	// Scoreboard: predict on each accepted input, compare on each accepted output
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			if (known_q.pop_front())
				pending_areas.push_back(known_area_q.pop_front());
			else
				pending_areas.push_back(heron_area(make_tri('{a_x, a_y, a_z, b_x, b_y,
					b_z, c_x, c_y, c_z}, 0, '0)));
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_areas.size() == 0) begin
				$error("area: unexpected transaction, actual %0d", area);
				errors++;
			end else if (area !== pending_areas[0]) begin
				$error("area: expected %0d, actual %0d", pending_areas[0], area);
				errors++;
				void'(pending_areas.pop_front());
			end else
				void'(pending_areas.pop_front());
		end
	end

	// Sender and run control
	initial begin
		triangle_t t;
		errors   = 0;
		sent     = 0;
		draining = 1'b0;
		snd_idle = 34;
		rcv_idle = 76;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} = '0;
		build_stimulus();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (sent < triangles.size() || (in_valid && in_stall)) begin
			@(posedge clk);
			if (in_valid && in_stall)
				continue;                       // hold the stalled transaction
			// idle mix: receiver-heavy, then sender-heavy, then none
			if (sent > triangles.size() * 2 / 3) begin
				snd_idle = 0;
				rcv_idle = 0;
			end else if (sent > triangles.size() / 3) begin
				snd_idle = 76;
				rcv_idle = 34;
			end
			if (sent == PAUSE_AT && !draining) begin
				draining = 1'b1;
				in_valid <= 1'b0;
				continue;
			end
			if (draining && pending_areas.size() != 0 && sent == PAUSE_AT) begin
				in_valid <= 1'b0;
				continue;
			end
			if (sent >= triangles.size() || $urandom_range(0, 99) < snd_idle) begin
				in_valid <= 1'b0;
				continue;
			end
			t = triangles[sent];
			known_q.push_back(t.known);
			if (t.known)
				known_area_q.push_back(t.area);
			a_x <= t.crd[0]; a_y <= t.crd[1]; a_z <= t.crd[2];
			b_x <= t.crd[3]; b_y <= t.crd[4]; b_z <= t.crd[5];
			c_x <= t.crd[6]; c_y <= t.crd[7]; c_z <= t.crd[8];
			in_valid <= 1'b1;
			sent++;
		end
		// keep the last transaction up until it is taken
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		in_valid <= 1'b0;
		while (pending_areas.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
